// File: src/imc_pkg.sv
// ----------------------------------------------------------------------------
// imc_pkg
// Shared widths, codes and types of the IMU motion classifier.
// ----------------------------------------------------------------------------
package imc_pkg;

    // Ring geometry and sample format
    localparam int RING_DEPTH        = 256;
    localparam int SAMPLE_BITS       = 16;
    localparam int ROLLBACK_FLOOR_NS = 100000000;

    // Fixed field widths
    localparam int TIME_W     = 63;
    localparam int WIN_W      = 36;
    localparam int SIG_W      = 15;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;

    // Derived widths
    localparam int AW      = $clog2(RING_DEPTH);
    localparam int FW      = $clog2(RING_DEPTH + 1);
    localparam int SUM_W   = SAMPLE_BITS + AW;
    localparam int SQ_W    = 2 * SAMPLE_BITS + AW;
    localparam int SMP_W   = 3 * SAMPLE_BITS;
    localparam int ENTRY_W = TIME_W + SMP_W;
    localparam int PAIR_W  = 2 * FW;
    localparam int S2_W    = 2 * SIG_W;
    localparam int LIM_W   = S2_W + 7 + PAIR_W;
    localparam int DW      = FW + SQ_W;
    localparam int MAG2_W  = 2 * SUM_W;
    localparam int CMP_W   = (LIM_W > DW) ? LIM_W : DW;

    localparam logic [WIN_W-1:0] FLOOR_NS     = WIN_W'(ROLLBACK_FLOOR_NS);
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000000000);
    localparam logic [SIG_W-1:0] SIGMA_RESET  = SIG_W'(8);
    localparam logic [FW-1:0]    FILL_FULL    = FW'(RING_DEPTH);
    localparam logic [AW-1:0]    HEAD_LAST    = AW'(RING_DEPTH - 1);

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_WINDOW_NS    = 3'd0;
    localparam cfg_idx_t REG_GYRO_SIGMA   = 3'd1;
    localparam cfg_idx_t REG_ACCEL_SIGMA  = 3'd2;
    localparam cfg_idx_t REG_GYRO_ENABLE  = 3'd3;
    localparam cfg_idx_t REG_ACCEL_ENABLE = 3'd4;

    // Sample kinds; the unnamed-sensor kinds only advance time
    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_NONE  = 2'd0;
    localparam kind_t KIND_GYRO  = 2'd1;
    localparam kind_t KIND_ACCEL = 2'd2;
    localparam kind_t KIND_SPARE = 2'd3;

    // Motion classes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t CLASS_NONE   = 2'd0;
    localparam status_t CLASS_STILL  = 2'd1;
    localparam status_t CLASS_MOVE   = 2'd2;
    localparam status_t CLASS_BUSY   = 2'd3;

    // Sensor select
    localparam logic SENS_GYRO  = 1'b0;
    localparam logic SENS_ACCEL = 1'b1;

    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROLL,
        ST_APPEND,
        ST_EV_RD,
        ST_EV_CHK,
        ST_SP_RD1,
        ST_SP_RD2,
        ST_SP_CALC,
        ST_CL_PAIRS,
        ST_CL_LIM,
        ST_CL_MUL,
        ST_CL_CMP,
        ST_DONE
    } state_t;

endpackage

// File: src/imu_sliding_window_motion_classifier_core.sv
// ----------------------------------------------------------------------------
// imu_sliding_window_motion_classifier_core
// Sliding-window variance motion classifier for gyro and accel samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one timestamped three-axis sample per item. Result
//   channel m_*: exactly one result per item, in order. Both use valid/ready.
//   cfg_wr_en/cfg_index/cfg_data write a register; writes are
//   expected only while the block is idle.
//   Processing time grows with each evicted entry, with a full ring dropping
//   its oldest entry, and with each classified window; a window with fewer
//   than two entries is not classified. The eviction walk reads the ring
//   once per check, and the classification multipliers are shared by the
//   three axes, which are worked one after another. One item is in work at
//   a time; s_ready is high only while idle, so the next item can be taken
//   in the cycle after a result is loaded.
//   The result sits in an output register, so the next item is taken while
//   a finished result still waits; a stalled receiver holds the block only
//   when the next result is ready to be written.
//   Reset: synchronous, active low. Control and window registers return to
//   their reset values and both windows are empty at once; ring contents are
//   not cleared, as entries are only read after being written.
// ----------------------------------------------------------------------------
module imu_sliding_window_motion_classifier_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [imc_pkg::TIME_W-1:0]           s_sample_time,
    input  logic [imc_pkg::KIND_W-1:0]           s_sample_kind,
    input  logic signed [imc_pkg::SAMPLE_BITS-1:0] s_axis_x,
    input  logic signed [imc_pkg::SAMPLE_BITS-1:0] s_axis_y,
    input  logic signed [imc_pkg::SAMPLE_BITS-1:0] s_axis_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [imc_pkg::STATUS_W-1:0]         m_motion_status,
    output logic [imc_pkg::TIME_W-1:0]           m_latest_time,
    output logic [imc_pkg::FW-1:0]               m_gyro_count,
    output logic [imc_pkg::FW-1:0]               m_accel_count,
    output logic                                 m_window_restarted,
    input  logic                                 cfg_wr_en,
    input  logic [imc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [imc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import imc_pkg::*;

    localparam int SB = SAMPLE_BITS;

    state_t state_reg, state_next;

    // Configuration
    logic [WIN_W-1:0] window_reg;
    logic [SIG_W-1:0] sigma_reg [2];
    logic             enable_reg [2];

    // Latched item
    logic [TIME_W-1:0]    t_reg;
    kind_t                kind_reg;
    logic signed [SB-1:0] in_reg [3];

    // Window state
    logic [TIME_W-1:0]       newest_reg;
    logic [AW-1:0]           head_reg [2];
    logic [FW-1:0]           fill_reg [2];
    logic signed [SUM_W-1:0] sum_reg [2][3];
    logic [SQ_W-1:0]         sq_reg [2][3];
    logic [TIME_W-1:0]       first_reg [2];

    // Sequencing
    logic       cur_reg;
    logic       force_reg;
    logic       restart_reg;
    logic [1:0] axis_reg;
    status_t    worst_reg;

    // Classification datapath
    logic [PAIR_W-1:0] pairs_reg;
    logic [S2_W-1:0]   s2_reg;
    logic [LIM_W-1:0]  lim3_reg, lim10_reg;
    logic [DW-1:0]     prod1_reg;
    logic [MAG2_W-1:0] prod2_reg;

    // Output register
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [TIME_W-1:0] m_latest_reg;
    logic [FW-1:0]     m_gcount_reg, m_acount_reg;
    logic              m_restart_reg;

    // Ring ports
    logic [1:0]         ram_we;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr [2];
    logic [ENTRY_W-1:0] rd_data [2];
    logic [AW-1:0]      slot_idx [2];
    logic [AW-1:0]      last_idx [2];
    logic [AW-1:0]      head_inc;

    // Combinational helpers
    logic [WIN_W-1:0]        tol;
    logic                    roll;
    logic [TIME_W-1:0]       newest_roll;
    logic                    append_ok;
    logic                    app_sensor;
    logic                    full;
    logic [ENTRY_W-1:0]      cur_data;
    logic [TIME_W-1:0]       cur_time;
    logic                    expired;
    logic                    drop;
    logic signed [SB-1:0]    v [3];
    logic [SQ_W-1:0]         v_sq [3];
    logic [TIME_W-1:0]       span [2];
    logic [TIME_W-1:0]       span_max;
    logic                    nodata;
    logic                    cls [2];
    logic signed [SUM_W-1:0] sum_sel;
    logic [SUM_W-1:0]        mag;
    logic [S2_W+7-1:0]       s2x9, s2x100;
    logic [CMP_W-1:0]        d_val;
    status_t                 axis_cls;
    logic                    out_free;

    // Rings, one per sensor: {time, z, y, x}
    for (genvar g = 0; g < 2; g++) begin : g_ring
        imc_ram #(
            .WIDTH(ENTRY_W),
            .DEPTH(RING_DEPTH)
        ) u_ram (
            .clk    (aclk),
            .wr_en  (ram_we[g]),
            .wr_addr(wr_addr),
            .wr_data(wr_data),
            .rd_addr(rd_addr[g]),
            .rd_data(rd_data[g])
        );
    end

    // Ring indexes
    always_comb begin
        logic [FW:0] s_sum;
        logic [FW:0] s_last;
        for (int s = 0; s < 2; s++) begin
            s_sum  = (FW+1)'(head_reg[s]) + (FW+1)'(fill_reg[s]);
            s_last = s_sum - (FW+1)'(1);
            slot_idx[s] = (s_sum >= (FW+1)'(RING_DEPTH)) ?
                          AW'(s_sum - (FW+1)'(RING_DEPTH)) : AW'(s_sum);
            last_idx[s] = (s_last >= (FW+1)'(RING_DEPTH)) ?
                          AW'(s_last - (FW+1)'(RING_DEPTH)) : AW'(s_last);
        end
        head_inc = (head_reg[cur_reg] == HEAD_LAST) ? '0 : head_reg[cur_reg] + AW'(1);
    end

    // Rollback and append decisions
    always_comb begin
        tol = (window_reg > FLOOR_NS) ? window_reg : FLOOR_NS;
        roll = (t_reg != '0) && (newest_reg != '0) &&
               (({1'b0, t_reg} + 64'(tol)) < {1'b0, newest_reg});
        newest_roll = (roll || (t_reg > newest_reg)) ? t_reg : newest_reg;
        append_ok = ((kind_reg == KIND_GYRO) && enable_reg[SENS_GYRO]) ||
                    ((kind_reg == KIND_ACCEL) && enable_reg[SENS_ACCEL]);
        app_sensor = (kind_reg == KIND_ACCEL);
        full = !roll && (fill_reg[app_sensor] == FILL_FULL);
    end

    // Eviction check on the entry read from the head
    always_comb begin
        cur_data = rd_data[cur_reg];
        cur_time = cur_data[ENTRY_W-1 -: TIME_W];
        expired  = ({1'b0, cur_time} + 64'(window_reg)) < {1'b0, newest_reg};
        drop     = (fill_reg[cur_reg] != '0) && (force_reg || expired);
    end

    // Sample squares: new item on append, ring entry on eviction
    always_comb begin
        logic signed [2*SB-1:0] ve;
        logic signed [2*SB-1:0] p;
        for (int k = 0; k < 3; k++) begin
            v[k] = (state_reg == ST_APPEND) ? in_reg[k] : $signed(cur_data[k*SB +: SB]);
            ve = (2*SB)'(v[k]);
            p = ve * ve;
            v_sq[k] = SQ_W'($unsigned(p));
        end
    end

    // Span of each window
    always_comb begin
        logic [TIME_W-1:0] last_t;
        for (int s = 0; s < 2; s++) begin
            last_t = rd_data[s][ENTRY_W-1 -: TIME_W];
            cls[s] = fill_reg[s] >= FW'(2);
            span[s] = (cls[s] && (last_t > first_reg[s])) ? last_t - first_reg[s] : '0;
        end
        span_max = (span[SENS_ACCEL] > span[SENS_GYRO]) ? span[SENS_ACCEL] : span[SENS_GYRO];
        nodata = ((fill_reg[SENS_GYRO] == '0) && (fill_reg[SENS_ACCEL] == '0)) ||
                 (span_max < TIME_W'(window_reg >> 1));
    end

    // Classification arithmetic
    always_comb begin
        sum_sel = sum_reg[cur_reg][axis_reg];
        mag     = sum_sel[SUM_W-1] ? $unsigned(-sum_sel) : $unsigned(sum_sel);
        s2x9    = ((S2_W+7)'(s2_reg) << 3) + (S2_W+7)'(s2_reg);
        s2x100  = ((S2_W+7)'(s2_reg) << 6) + ((S2_W+7)'(s2_reg) << 5) +
                  ((S2_W+7)'(s2_reg) << 2);
        d_val   = CMP_W'(prod1_reg) - CMP_W'(prod2_reg);
        if (d_val <= CMP_W'(lim3_reg)) begin
            axis_cls = CLASS_STILL;
        end else if (d_val <= CMP_W'(lim10_reg)) begin
            axis_cls = CLASS_MOVE;
        end else begin
            axis_cls = CLASS_BUSY;
        end
        out_free = !m_valid_reg || m_ready;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_ROLL;
            end
            ST_ROLL: begin
                state_next = (append_ok && !full) ? ST_APPEND : ST_EV_RD;
            end
            ST_APPEND: state_next = ST_EV_RD;
            ST_EV_RD:  state_next = ST_EV_CHK;
            ST_EV_CHK: begin
                if (force_reg) begin
                    state_next = ST_APPEND;
                end else if (drop || (cur_reg == SENS_GYRO)) begin
                    state_next = ST_EV_RD;
                end else begin
                    state_next = ST_SP_RD1;
                end
            end
            ST_SP_RD1: state_next = ST_SP_RD2;
            ST_SP_RD2: state_next = ST_SP_CALC;
            ST_SP_CALC: begin
                state_next = (!nodata && (cls[SENS_GYRO] || cls[SENS_ACCEL])) ?
                             ST_CL_PAIRS : ST_DONE;
            end
            ST_CL_PAIRS: state_next = ST_CL_LIM;
            ST_CL_LIM:   state_next = ST_CL_MUL;
            ST_CL_MUL:   state_next = ST_CL_CMP;
            ST_CL_CMP: begin
                if (axis_reg != AXIS_LAST) begin
                    state_next = ST_CL_MUL;
                end else if ((cur_reg == SENS_GYRO) && cls[SENS_ACCEL]) begin
                    state_next = ST_CL_PAIRS;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Ring port control and handshake outputs
    always_comb begin
        ram_we = '0;
        if (state_reg == ST_APPEND) ram_we[cur_reg] = 1'b1;
        wr_addr = slot_idx[cur_reg];
        wr_data = {t_reg, in_reg[2], in_reg[1], in_reg[0]};
        for (int s = 0; s < 2; s++) begin
            rd_addr[s] = (state_reg == ST_SP_RD2) ? last_idx[s] : head_reg[s];
        end
        s_ready = (state_reg == ST_IDLE);
    end

    assign m_valid            = m_valid_reg;
    assign m_motion_status    = m_status_reg;
    assign m_latest_time      = m_latest_reg;
    assign m_gyro_count       = m_gcount_reg;
    assign m_accel_count      = m_acount_reg;
    assign m_window_restarted = m_restart_reg;

    // Control and window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            window_reg  <= WINDOW_RESET;
            sigma_reg[SENS_GYRO]   <= SIGMA_RESET;
            sigma_reg[SENS_ACCEL]  <= SIGMA_RESET;
            enable_reg[SENS_GYRO]  <= 1'b1;
            enable_reg[SENS_ACCEL] <= 1'b1;
            newest_reg  <= '0;
            cur_reg     <= SENS_GYRO;
            force_reg   <= 1'b0;
            restart_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int s = 0; s < 2; s++) begin
                head_reg[s] <= '0;
                fill_reg[s] <= '0;
                for (int k = 0; k < 3; k++) begin
                    sum_reg[s][k] <= '0;
                    sq_reg[s][k]  <= '0;
                end
            end
        end else begin
            state_reg <= state_next;

            // Register writes; disabling a sensor empties its window
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_WINDOW_NS:   window_reg <= cfg_data[WIN_W-1:0];
                    REG_GYRO_SIGMA:  sigma_reg[SENS_GYRO] <= cfg_data[SIG_W-1:0];
                    REG_ACCEL_SIGMA: sigma_reg[SENS_ACCEL] <= cfg_data[SIG_W-1:0];
                    REG_GYRO_ENABLE, REG_ACCEL_ENABLE: begin
                        enable_reg[cfg_index == REG_ACCEL_ENABLE] <= cfg_data[0];
                        if (!cfg_data[0]) begin
                            head_reg[cfg_index == REG_ACCEL_ENABLE] <= '0;
                            fill_reg[cfg_index == REG_ACCEL_ENABLE] <= '0;
                            for (int k = 0; k < 3; k++) begin
                                sum_reg[cfg_index == REG_ACCEL_ENABLE][k] <= '0;
                                sq_reg[cfg_index == REG_ACCEL_ENABLE][k]  <= '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // Result valid: set when a result is loaded, cleared when taken
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_ROLL: begin
                    restart_reg <= roll;
                    newest_reg  <= newest_roll;
                    if (roll) begin
                        for (int s = 0; s < 2; s++) begin
                            head_reg[s] <= '0;
                            fill_reg[s] <= '0;
                            for (int k = 0; k < 3; k++) begin
                                sum_reg[s][k] <= '0;
                                sq_reg[s][k]  <= '0;
                            end
                        end
                    end
                    cur_reg   <= append_ok ? app_sensor : SENS_GYRO;
                    force_reg <= append_ok && full;
                end
                ST_EV_CHK: begin
                    if (drop) begin
                        for (int k = 0; k < 3; k++) begin
                            sum_reg[cur_reg][k] <= sum_reg[cur_reg][k] - SUM_W'(v[k]);
                            sq_reg[cur_reg][k]  <= sq_reg[cur_reg][k] - v_sq[k];
                        end
                        head_reg[cur_reg] <= head_inc;
                        fill_reg[cur_reg] <= fill_reg[cur_reg] - FW'(1);
                    end
                    if (force_reg) begin
                        force_reg <= 1'b0;
                    end else if (!drop && (cur_reg == SENS_GYRO)) begin
                        cur_reg <= SENS_ACCEL;
                    end
                end
                ST_APPEND: begin
                    for (int k = 0; k < 3; k++) begin
                        sum_reg[cur_reg][k] <= sum_reg[cur_reg][k] + SUM_W'(v[k]);
                        sq_reg[cur_reg][k]  <= sq_reg[cur_reg][k] + v_sq[k];
                    end
                    fill_reg[cur_reg] <= fill_reg[cur_reg] + FW'(1);
                    cur_reg <= SENS_GYRO;
                end
                ST_SP_CALC: begin
                    cur_reg <= cls[SENS_GYRO] ? SENS_GYRO : SENS_ACCEL;
                end
                ST_CL_CMP: begin
                    if (axis_reg == AXIS_LAST) cur_reg <= SENS_ACCEL;
                end
                default: ;
            endcase
        end
    end

    // Item, classification and result payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    t_reg     <= s_sample_time;
                    kind_reg  <= s_sample_kind;
                    in_reg[0] <= s_axis_x;
                    in_reg[1] <= s_axis_y;
                    in_reg[2] <= s_axis_z;
                end
            end
            ST_SP_RD2: begin
                for (int s = 0; s < 2; s++) begin
                    first_reg[s] <= rd_data[s][ENTRY_W-1 -: TIME_W];
                end
            end
            ST_SP_CALC: begin
                worst_reg <= nodata ? CLASS_NONE : CLASS_STILL;
            end
            ST_CL_PAIRS: begin
                pairs_reg <= PAIR_W'(fill_reg[cur_reg]) * PAIR_W'(fill_reg[cur_reg] - FW'(1));
                s2_reg    <= S2_W'(sigma_reg[cur_reg]) * S2_W'(sigma_reg[cur_reg]);
                axis_reg  <= '0;
            end
            ST_CL_LIM: begin
                lim3_reg  <= LIM_W'(s2x9) * LIM_W'(pairs_reg);
                lim10_reg <= LIM_W'(s2x100) * LIM_W'(pairs_reg);
            end
            ST_CL_MUL: begin
                prod1_reg <= DW'(fill_reg[cur_reg]) * DW'(sq_reg[cur_reg][axis_reg]);
                prod2_reg <= MAG2_W'(mag) * MAG2_W'(mag);
            end
            ST_CL_CMP: begin
                if (axis_cls > worst_reg) worst_reg <= axis_cls;
                axis_reg <= axis_reg + 2'd1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_status_reg  <= worst_reg;
                    m_latest_reg  <= newest_reg;
                    m_gcount_reg  <= fill_reg[SENS_GYRO];
                    m_acount_reg  <= fill_reg[SENS_ACCEL];
                    m_restart_reg <= restart_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: src/imc_ram.sv
// ----------------------------------------------------------------------------
// imc_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module imc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/imc_checker.sv
// ----------------------------------------------------------------------------
// imc_checker
// Port-level checks of the motion classifier, bound to the top level.
// ----------------------------------------------------------------------------
module imc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [imc_pkg::STATUS_W-1:0]  m_motion_status,
    input logic [imc_pkg::TIME_W-1:0]    m_latest_time,
    input logic [imc_pkg::FW-1:0]        m_gyro_count,
    input logic [imc_pkg::FW-1:0]        m_accel_count,
    input logic                          m_window_restarted
);

    import imc_pkg::*;

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_motion_status)
                                && $stable(m_latest_time))
        else $error("stalled result changed");

    // Window fill never exceeds ring depth
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gyro_count <= FILL_FULL) && (m_accel_count <= FILL_FULL))
        else $error("window count beyond ring depth");

    // A motion class needs at least one filled window
    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_motion_status != CLASS_NONE)
            |-> (m_gyro_count != '0) || (m_accel_count != '0))
        else $error("motion class with empty windows");

    // A restart is only caused by a known timestamp
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_window_restarted |-> m_latest_time != '0)
        else $error("restart with zero latest time");

endmodule

bind imu_sliding_window_motion_classifier_core imc_checker u_imc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_motion_status   (m_motion_status),
    .m_latest_time     (m_latest_time),
    .m_gyro_count      (m_gyro_count),
    .m_accel_count     (m_accel_count),
    .m_window_restarted(m_window_restarted)
);

// File: tb/imu_motion_checker.sv
// ----------------------------------------------------------------------------
// imu_motion_checker
// Watches both channels of the motion classifier, keeps its own copy of the
// window state, predicts one result per accepted item and compares.
// ----------------------------------------------------------------------------
module imu_motion_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic [imc_pkg::TIME_W-1:0]             s_sample_time,
    input  logic [imc_pkg::KIND_W-1:0]             s_sample_kind,
    input  logic signed [imc_pkg::SAMPLE_BITS-1:0] s_axis_x,
    input  logic signed [imc_pkg::SAMPLE_BITS-1:0] s_axis_y,
    input  logic signed [imc_pkg::SAMPLE_BITS-1:0] s_axis_z,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic [imc_pkg::STATUS_W-1:0]           m_motion_status,
    input  logic [imc_pkg::TIME_W-1:0]             m_latest_time,
    input  logic [imc_pkg::FW-1:0]                 m_gyro_count,
    input  logic [imc_pkg::FW-1:0]                 m_accel_count,
    input  logic                                   m_window_restarted,
    input  logic                                   cfg_wr_en,
    input  logic [imc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [imc_pkg::CFG_DATA_W-1:0]         cfg_data,
    output int                                     fail_count,
    output int                                     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import imc_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [TIME_W-1:0] latest;
        logic [FW-1:0]     gcnt;
        logic [FW-1:0]     acnt;
        logic              restarted;
    } motion_result_t;

    // Sensor windows: index 0 gyro, 1 accel
    logic [TIME_W-1:0]   ring_time [2][RING_DEPTH];
    longint              ring_smp  [2][RING_DEPTH][3];
    int                  head [2];
    int                  fill [2];
    longint              axsum [2][3];
    longint              axsq  [2][3];
    logic [TIME_W-1:0]   newest;
    logic [WIN_W-1:0]    win_ns;
    logic [SIG_W-1:0]    sigma [2];
    logic                enable [2];

    motion_result_t      expected_results[$];

    function automatic void clear_window(int s);
        head[s] = 0;
        fill[s] = 0;
        for (int i = 0; i < 3; i++) begin
            axsum[s][i] = 0;
            axsq[s][i]  = 0;
        end
    endfunction

    function automatic void drop_oldest(int s);
        if (fill[s] == 0) return;
        for (int i = 0; i < 3; i++) begin
            axsum[s][i] -= ring_smp[s][head[s]][i];
            axsq[s][i]  -= ring_smp[s][head[s]][i] * ring_smp[s][head[s]][i];
        end
        head[s] = (head[s] + 1) % RING_DEPTH;
        fill[s]--;
    endfunction

    function automatic logic [63:0] window_span(int s);
        logic [TIME_W-1:0] first, last;
        if (fill[s] < 2) return 0;
        first = ring_time[s][head[s]];
        last  = ring_time[s][(head[s] + fill[s] - 1) % RING_DEPTH];
        return (last > first) ? 64'(last - first) : 64'd0;
    endfunction

    // Exact variance test: n*sq - sum^2 against k^2 sigma^2 n(n-1)
    function automatic int window_grade(int s);
        logic [127:0] pairs, s2, lim3, lim10, d, mag;
        int worst;
        worst = 1;
        if (fill[s] < 2) return 1;
        pairs = 128'(fill[s]) * 128'(fill[s] - 1);
        s2    = 128'(sigma[s]) * 128'(sigma[s]);
        lim3  = 9 * s2 * pairs;
        lim10 = 100 * s2 * pairs;
        for (int i = 0; i < 3; i++) begin
            mag = (axsum[s][i] < 0) ? 128'(-axsum[s][i]) : 128'(axsum[s][i]);
            d = 128'(fill[s]) * 128'(axsq[s][i]) - mag * mag;
            if (d > lim10) worst = 3;
            else if (d > lim3 && worst < 2) worst = 2;
        end
        return worst;
    endfunction

    function automatic motion_result_t classify_item(logic [TIME_W-1:0] t, kind_t kind,
                                                     longint vx, longint vy, longint vz);
        motion_result_t r;
        logic [63:0] tol, span, sa;
        int s, slot, c;
        r.restarted = 1'b0;
        tol = (win_ns > FLOOR_NS) ? 64'(win_ns) : 64'(FLOOR_NS);
        if (t > 0 && newest > 0 && 64'(t) + tol < 64'(newest)) begin
            clear_window(0);
            clear_window(1);
            newest = '0;
            r.restarted = 1'b1;
        end
        if (t > newest) newest = t;
        s = (kind == KIND_GYRO) ? 0 : (kind == KIND_ACCEL) ? 1 : -1;
        if (s >= 0 && enable[s]) begin
            if (fill[s] >= RING_DEPTH) drop_oldest(s);
            slot = (head[s] + fill[s]) % RING_DEPTH;
            ring_time[s][slot] = t;
            ring_smp[s][slot][0] = vx;
            ring_smp[s][slot][1] = vy;
            ring_smp[s][slot][2] = vz;
            axsum[s][0] += vx; axsq[s][0] += vx * vx;
            axsum[s][1] += vy; axsq[s][1] += vy * vy;
            axsum[s][2] += vz; axsq[s][2] += vz * vz;
            fill[s]++;
        end
        // Evict from the oldest end only
        for (int w = 0; w < 2; w++)
            while (fill[w] > 0 && 64'(ring_time[w][head[w]]) + 64'(win_ns) < 64'(newest))
                drop_oldest(w);
        span = window_span(0);
        sa = window_span(1);
        if (sa > span) span = sa;
        if ((fill[0] == 0 && fill[1] == 0) || span < 64'(win_ns >> 1)) begin
            r.status = CLASS_NONE;
        end else begin
            r.status = CLASS_STILL;
            for (int w = 0; w < 2; w++)
                if (fill[w] > 0) begin
                    c = window_grade(w);
                    if (c > int'(r.status)) r.status = status_t'(c);
                end
        end
        r.latest = newest;
        r.gcnt = FW'(fill[0]);
        r.acnt = FW'(fill[1]);
        return r;
    endfunction

    assign pending_count = expected_results.size();

    // Config writes, input prediction and output comparison
    always @(posedge aclk) begin
        motion_result_t want, got;
        if (!aresetn) begin
            win_ns <= WINDOW_RESET;
            sigma[0] = SIGMA_RESET;
            sigma[1] = SIGMA_RESET;
            enable[0] = 1'b1;
            enable[1] = 1'b1;
            clear_window(0);
            clear_window(1);
            newest = '0;
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_WINDOW_NS:   win_ns <= cfg_data[WIN_W-1:0];
                    REG_GYRO_SIGMA:  sigma[0] = cfg_data[SIG_W-1:0];
                    REG_ACCEL_SIGMA: sigma[1] = cfg_data[SIG_W-1:0];
                    REG_GYRO_ENABLE: begin
                        enable[0] = cfg_data[0];
                        if (!cfg_data[0]) clear_window(0);
                    end
                    REG_ACCEL_ENABLE: begin
                        enable[1] = cfg_data[0];
                        if (!cfg_data[0]) clear_window(1);
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(),
                    classify_item(s_sample_time, s_sample_kind,
                    longint'(s_axis_x), longint'(s_axis_y), longint'(s_axis_z)));
            if (m_valid && m_ready) begin
                got = '{m_motion_status, m_latest_time, m_gyro_count, m_accel_count,
                        m_window_restarted};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (want != got) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/imu_sliding_window_motion_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// imu_sliding_window_motion_classifier_core_tb
// Drives timestamped gyro and accel items with random idling, sweeps the
// configuration between phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
module imu_sliding_window_motion_classifier_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imc_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic [TIME_W-1:0] s_sample_time;
    logic [KIND_W-1:0] s_sample_kind;
    logic signed [SAMPLE_BITS-1:0] s_axis_x, s_axis_y, s_axis_z;
    logic [STATUS_W-1:0] m_motion_status;
    logic [TIME_W-1:0] m_latest_time;
    logic [FW-1:0] m_gyro_count, m_accel_count;
    logic m_window_restarted;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int fail_count, pending_count;
    int idle_cycles;
    bit calm;          // no idling in the final phase
    bit sink_hold;     // long receiver hold-off request
    logic [TIME_W-1:0] clock_ns;

    imu_sliding_window_motion_classifier_core uut (.*);
    imu_motion_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on handshakes
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (sink_hold) begin
                m_ready <= 0;
                repeat (400) @(negedge aclk);
                sink_hold = 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 19);
                m_ready <= 0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready <= 1;
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 0;
    endtask

    // Drop valid after the last item, then wait for every result
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 0;
        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // Returns at the accepting edge; valid stays high into the next item
    task automatic send_sample(logic [TIME_W-1:0] t, kind_t k,
                               logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int n;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 19);
            s_valid <= 0;
            repeat (n) @(negedge aclk);
        end
        s_valid <= 1;
        s_sample_time <= t;
        s_sample_kind <= k;
        s_axis_x <= x;
        s_axis_y <= y;
        s_axis_z <= z;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Small spread around zero or full-range noise
    function automatic logic [15:0] axis_value(int spread);
        return (spread < 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * spread) - spread);
    endfunction

    task automatic random_phase(int count, int step_max, int spread);
        int r;
        logic [TIME_W-1:0] t;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            clock_ns += $urandom_range(0, step_max);
            t = clock_ns;
            if (r < 3) t = TIME_W'(clock_ns - $urandom_range(0, 2) * 64'd1000000000);
            else if (r < 5) t = 0;
            else if (r < 6) t = TIME_W'({$urandom, $urandom});
            send_sample(t, kind_t'(r < 8 ? $urandom_range(0, 3) : $urandom_range(1, 2)),
                        axis_value(r > 90 ? -1 : spread), axis_value(spread),
                        axis_value(r > 95 ? -1 : spread));
            if (t > clock_ns && t < 64'h4000_0000_0000_0000) clock_ns = t;
        end
    endtask

    initial begin
        s_valid = 0; s_sample_time = 0; s_sample_kind = 0;
        s_axis_x = 0; s_axis_y = 0; s_axis_z = 0;
        cfg_wr_en = 0; cfg_index = REG_WINDOW_NS; cfg_data = 0;
        calm = 0; sink_hold = 0; clock_ns = 1000;
        aresetn = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1;

        // Directed: extremes, kinds, unknown time, rollback, max time
        send_sample(0, KIND_GYRO, 16'h7FFF, 16'h8000, 16'h0000);
        send_sample(1000, KIND_GYRO, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_sample(600000000, KIND_GYRO, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(700000000, KIND_ACCEL, 16'h0001, 16'h0002, 16'h0003);
        send_sample(800000000, KIND_ACCEL, 16'h0001, 16'h0002, 16'h0004);
        send_sample(900000000, KIND_NONE, 0, 0, 0);
        send_sample(900000000, KIND_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(63'd2500000000, KIND_ACCEL, 16'h0005, 16'h0000, 16'h0000);
        send_sample(1000, KIND_GYRO, 16'h0010, 16'h0000, 16'h0000);
        send_sample({TIME_W{1'b1}}, KIND_GYRO, 16'h0001, 0, 0);
        send_sample({TIME_W{1'b1}} - 5, KIND_GYRO, 16'hFFF0, 0, 0);
        send_sample(5, KIND_ACCEL, 0, 0, 0);
        // Sender pause until all results are back
        drain_results();

        // Long run with a huge window, receiver held off
        write_reg(REG_WINDOW_NS, 36'hF_FFFF_FFFF);
        write_reg(REG_GYRO_SIGMA, 0);
        clock_ns = 1000;
        sink_hold = 1;
        random_phase(300, 3, 4);
        drain_results();

        write_reg(REG_WINDOW_NS, 1);
        write_reg(REG_ACCEL_SIGMA, 32767);
        write_reg(REG_GYRO_ENABLE, 0);
        random_phase(100, 5, -1);
        drain_results();

        write_reg(REG_GYRO_ENABLE, 1);
        write_reg(REG_ACCEL_ENABLE, 0);
        write_reg(REG_WINDOW_NS, 36'd60000000000);
        write_reg(REG_GYRO_SIGMA, 3);
        random_phase(150, 400000000, 40);
        drain_results();

        write_reg(REG_ACCEL_ENABLE, 1);
        write_reg(REG_WINDOW_NS, 50000000);
        write_reg(REG_GYRO_SIGMA, 2);
        write_reg(REG_ACCEL_SIGMA, 5);
        random_phase(200, 4000000, 30);
        drain_results();

        write_reg(REG_WINDOW_NS, 1000000000);
        write_reg(REG_GYRO_SIGMA, 8);
        write_reg(REG_ACCEL_SIGMA, 1);
        calm = 1;
        random_phase(150, 30000000, 20);
        drain_results();

        if (fail_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
